[hw/rtl/crccsr_pkg.sv]
`default_nettype none

package crccsr_pkg;

	localparam int unsigned PayloadLimitDefault = 1000;

	localparam int unsigned PosW     = 11;
	localparam int unsigned ReplyIdxW = 6;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 48;

	localparam logic [15:0] CrcPoly   = 16'h1021;
	localparam logic [15:0] CmdSearch = 16'hff01;
	localparam logic [7:0]  LeadByte0 = 8'hfa;
	localparam logic [7:0]  LeadByte1 = 8'h01;

	// frame layout
	localparam logic [PosW-1:0] PosLead0 = 11'd0;
	localparam logic [PosW-1:0] PosLead1 = 11'd1;
	localparam logic [PosW-1:0] PosCmdHi = 11'd18;
	localparam logic [PosW-1:0] PosCmdLo = 11'd19;
	localparam logic [PosW-1:0] PosLenHi = 11'd26;
	localparam logic [PosW-1:0] PosLenLo = 11'd27;
	localparam logic [PosW-1:0] HdrLen   = 11'd28;

	// reply layout
	localparam logic [ReplyIdxW-1:0] ReplyCrcIdx  = 6'd40;
	localparam logic [ReplyIdxW-1:0] ReplyLastIdx = 6'd41;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgDevType = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgMac     = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgIp      = 2'd2;

	// crc-16, poly 1021, msb first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			if (c[15] ^ b[7-k])
				c = {c[14:0], 1'b0} ^ CrcPoly;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] reply_byte_at(
		input logic [ReplyIdxW-1:0] idx,
		input logic [7:0]           dev,
		input logic [47:0]          mac,
		input logic [31:0]          ip,
		input logic [15:0]          crc
	);
		logic [7:0] r;
		case (idx)
			6'd0:  r = LeadByte0;
			6'd1:  r = LeadByte1;
			6'd2:  r = 8'h34;
			6'd3:  r = 8'h33;
			6'd4:  r = 8'h21;
			6'd5:  r = 8'h56;
			6'd6:  r = 8'h23;
			6'd7:  r = 8'ha5;
			6'd8:  r = 8'h7b;
			6'd9:  r = 8'h29;
			6'd10: r = 8'hc5;
			6'd11: r = 8'h5d;
			6'd12: r = 8'h3c;
			6'd13: r = 8'h32;
			6'd14: r = 8'h12;
			6'd15: r = 8'hfe;
			6'd18: r = 8'hff;
			6'd19: r = 8'h02;
			6'd20: r = dev;
			6'd27: r = 8'h0c;
			6'd28: r = mac[47:40];
			6'd29: r = mac[39:32];
			6'd30: r = mac[31:24];
			6'd31: r = mac[23:16];
			6'd32: r = mac[15:8];
			6'd33: r = mac[7:0];
			6'd34: r = ip[31:24];
			6'd35: r = ip[23:16];
			6'd36: r = ip[15:8];
			6'd37: r = ip[7:0];
			6'd38: r = 8'h02;
			6'd39: r = 8'h16;
			6'd40: r = crc[7:0];
			6'd41: r = crc[15:8];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/crc_checked_search_request_responder_top.sv]
// Search-request responder: takes received frame bytes one beat per cycle unless stalled, checks the
// FA 01 lead bytes, the payload length (bytes 26-27, below PAYLOAD_LIMIT), the command
// word FF01 (bytes 18-19) and the CRC-16 (poly 1021, init 0) in the two bytes after the
// payload, and on a match sends a 42-byte search reply, one beat per cycle while m_tready
// is high, starting the cycle after the CRC low byte is taken. The input side stalls only
// when a frame reaches its CRC low byte while an earlier reply is still going out, since
// the single reply sequencer holds one reply at a time.
// Reply fields come from the device type, MAC and IP registers written on the cfg port.
`default_nettype none

module crc_checked_search_request_responder_top
	import crccsr_pkg::*;
#(
	parameter int unsigned PAYLOAD_LIMIT = PayloadLimitDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // [7:0] rx_byte
	input  wire logic                s_tlast,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,   // [7:0] reply_byte
	output logic                     m_tlast,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	logic [7:0]  dev_q;
	logic [47:0] mac_q;
	logic [31:0] ip_q;

	logic beat;
	logic go;
	logic crc_lo_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= '0;
			mac_q <= '0;
			ip_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgDevType: dev_q <= cfg_data[7:0];
				CfgMac:     mac_q <= cfg_data[47:0];
				CfgIp:      ip_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// hold the crc low byte back while a reply is still in flight
	assign s_tready = !(crc_lo_next && m_tvalid);
	assign beat     = s_tvalid && s_tready;

	crccsr_parse #(
		.PAYLOAD_LIMIT(PAYLOAD_LIMIT)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat        (beat),
		.rx_byte     (s_tdata),
		.frame_end   (s_tlast),
		.go          (go),
		.crc_lo_next (crc_lo_next)
	);

	crccsr_reply u_reply (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.dev    (dev_q),
		.mac    (mac_q),
		.ip     (ip_q),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.data   (m_tdata),
		.last   (m_tlast)
	);

`ifndef NO_ASSERTIONS
	a_go_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !m_tvalid)
		else $error("reply started while previous reply active");

	a_reply_starts_lead: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (m_tdata == LeadByte0 && !m_tlast))
		else $error("reply does not start with lead byte");

	a_reply_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || $past(go)))
		else $error("reply continues after last beat");
`endif

endmodule

`default_nettype wire

[hw/rtl/crccsr_parse.sv]
`default_nettype none

module crccsr_parse
	import crccsr_pkg::*;
#(
	parameter int unsigned PAYLOAD_LIMIT = PayloadLimitDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       beat,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_end,
	output logic            go,
	output logic            crc_lo_next
);

	localparam logic [15:0] LimitV = 16'(PAYLOAD_LIMIT);

	logic [PosW-1:0] pos_q;
	logic [15:0]     len_q;
	logic [15:0]     cmd_q;
	logic [15:0]     crc_q;
	logic [7:0]      crc_hi_q;
	logic            done_q;

	logic [16:0] crc_at;
	logic [16:0] pos_ext;
	logic        hdr_bad;
	logic        in_body;
	logic        at_crc_hi;
	logic        at_crc_lo;
	logic [15:0] len_lo_new;
	logic        len_bad;
	logic        done_next;

	always_comb begin
		crc_at     = {1'b0, len_q} + 17'(HdrLen);
		pos_ext    = 17'(pos_q);
		hdr_bad    = (pos_q == PosLead0 && rx_byte != LeadByte0) ||
		             (pos_q == PosLead1 && rx_byte != LeadByte1);
		in_body    = (pos_ext < crc_at) || (pos_q < HdrLen);
		at_crc_hi  = !in_body && (pos_ext == crc_at);
		at_crc_lo  = !in_body && !at_crc_hi;
		len_lo_new = {len_q[15:8], rx_byte};
		len_bad    = (pos_q == PosLenLo) && (len_lo_new >= LimitV);
		done_next  = hdr_bad || (in_body && len_bad) || at_crc_lo;
		go          = beat && !done_q && !hdr_bad && at_crc_lo &&
		              ({crc_hi_q, rx_byte} == crc_q) && (cmd_q == CmdSearch);
		crc_lo_next = !done_q && at_crc_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			cmd_q    <= '0;
			crc_q    <= '0;
			crc_hi_q <= '0;
			done_q   <= 1'b0;
		end else if (beat) begin
			if (frame_end) begin
				pos_q    <= '0;
				len_q    <= '0;
				cmd_q    <= '0;
				crc_q    <= '0;
				crc_hi_q <= '0;
				done_q   <= 1'b0;
			end else if (!done_q) begin
				if (in_body && !hdr_bad) begin
					crc_q <= crc16_byte(crc_q, rx_byte);
					case (pos_q)
						PosCmdHi: cmd_q <= {rx_byte, cmd_q[7:0]};
						PosCmdLo: cmd_q <= {cmd_q[15:8], rx_byte};
						PosLenHi: len_q <= {rx_byte, len_q[7:0]};
						PosLenLo: len_q <= len_lo_new;
						default: ;
					endcase
				end else if (at_crc_hi) begin
					crc_hi_q <= rx_byte;
				end
				done_q <= done_next;
				// position saturates at its top value
				if (!done_next && pos_q != '1)
					pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/crccsr_reply.sv]
`default_nettype none

module crccsr_reply
	import crccsr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [7:0]  dev,
	input  wire logic [47:0] mac,
	input  wire logic [31:0] ip,
	output logic             valid,
	input  wire logic        ready,
	output logic [7:0]       data,
	output logic             last
);

	logic                 vld_q;
	logic [ReplyIdxW-1:0] idx_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	logic [15:0]          crc_q;

	logic                 adv;
	logic [ReplyIdxW-1:0] idx_n;
	logic [15:0]          crc_n;
	logic [7:0]           byte_n;

	always_comb begin
		adv    = vld_q && ready;
		idx_n  = idx_q + 1'b1;
		// crc covers the bytes before the crc field only
		crc_n  = (idx_q < ReplyCrcIdx) ? crc16_byte(crc_q, byte_q) : crc_q;
		byte_n = reply_byte_at(idx_n, dev, mac, ip, crc_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (go) begin
			vld_q <= 1'b1;
			idx_q <= '0;
		end else if (adv) begin
			if (last_q)
				vld_q <= 1'b0;
			else
				idx_q <= idx_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			byte_q <= LeadByte0;
			last_q <= 1'b0;
			crc_q  <= '0;
		end else if (adv && !last_q) begin
			byte_q <= byte_n;
			last_q <= (idx_n == ReplyLastIdx);
			crc_q  <= crc_n;
		end
	end

	assign valid = vld_q;
	assign data  = byte_q;
	assign last  = last_q;

endmodule

`default_nettype wire

[sim/crc_checked_search_request_responder_top_tb.sv]
`default_nettype none

module crc_checked_search_request_responder_top_tb;
	import crccsr_pkg::*;

	localparam int ClkPeriod    = 20;
	localparam int SettleCycles = 16;
	localparam int TailCycles   = 60;
	localparam int RandomItems  = 100;

	localparam logic [CfgIdxW-1:0] CfgNone = 2'd3;

	localparam logic [143:0] ReplyHead    = 144'hfa01_3433_2156_23a5_7b29_c55d_3c32_12fe_0000;
	localparam logic [15:0]  ReplyCmd     = 16'hff02;
	localparam logic [7:0]   ReplyAddrLen = 8'h0c;
	localparam logic [15:0]  ReplyTrailer = 16'h0216;
	localparam int           ReplyBeats   = 42;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_beat_t;

	typedef enum int {
		FrmSearch,
		FrmOtherCmd,
		FrmBadCrc,
		FrmCutShort,
		FrmBadLead0,
		FrmBadLead1,
		FrmTooLong,
		FrmNoise
	} frame_kind_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;
	logic                m_tlast;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// device registers as the block should hold them
	logic [7:0]  dev_type_q;
	logic [47:0] mac_q;
	logic [31:0] ip_q;

	// receive-side parser state
	logic [PosW-1:0] rx_pos;
	logic            rx_lead_ok;
	logic [15:0]     rx_len;
	logic [15:0]     rx_cmd;
	logic [15:0]     rx_crc;
	logic [7:0]      rx_crc_hi;
	logic            rx_skip;

	reply_beat_t pending_reply_beats[$];
	logic [7:0]  frame_buf[$];

	bit idle_on = 1'b0;
	int stall_left = 0;
	int mismatch_count = 0;

	crc_checked_search_request_responder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] rx_byte
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] reply_byte
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb)
				c = c ^ CrcPoly;
		end
		return c;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void log_mismatch(input string msg);
		if (mismatch_count < 10)
			$display("mismatch: %s", msg);
		mismatch_count++;
	endfunction

	task automatic clear_frame();
		rx_pos = '0;
		rx_lead_ok = 1'b0;
		rx_len = '0;
		rx_cmd = '0;
		rx_crc = '0;
		rx_crc_hi = '0;
		rx_skip = 1'b0;
	endtask

	task automatic queue_search_reply();
		logic [7:0]  r [ReplyBeats];
		logic [15:0] c;
		reply_beat_t beat;
		for (int i = 0; i < 18; i++)
			r[i] = ReplyHead[143 - 8 * i -: 8];
		r[18] = ReplyCmd[15:8];
		r[19] = ReplyCmd[7:0];
		r[20] = dev_type_q;
		for (int i = 21; i < 27; i++)
			r[i] = 8'h00;
		r[27] = ReplyAddrLen;
		for (int i = 0; i < 6; i++)
			r[28 + i] = mac_q[47 - 8 * i -: 8];
		for (int i = 0; i < 4; i++)
			r[34 + i] = ip_q[31 - 8 * i -: 8];
		r[38] = ReplyTrailer[15:8];
		r[39] = ReplyTrailer[7:0];
		c = '0;
		for (int i = 0; i < 40; i++)
			c = crc_next(c, r[i]);
		// reply crc goes out low byte first
		r[40] = c[7:0];
		r[41] = c[15:8];
		for (int i = 0; i < ReplyBeats; i++) begin
			beat.data = r[i];
			beat.last = (i == ReplyBeats - 1);
			pending_reply_beats.push_back(beat);
		end
	endtask

	task automatic track_rx_byte(input logic [7:0] b, input logic last);
		int crc_at;
		if (!rx_skip) begin
			if (rx_pos == PosLead0) begin
				rx_lead_ok = (b == LeadByte0);
				if (!rx_lead_ok)
					rx_skip = 1'b1;
			end else if (rx_pos == PosLead1) begin
				rx_lead_ok = rx_lead_ok && (b == LeadByte1);
				if (!rx_lead_ok)
					rx_skip = 1'b1;
			end
			if (!rx_skip) begin
				crc_at = int'(HdrLen) + int'(rx_len);
				if (int'(rx_pos) < crc_at) begin
					rx_crc = crc_next(rx_crc, b);
					if (rx_pos == PosCmdHi)
						rx_cmd[15:8] = b;
					else if (rx_pos == PosCmdLo)
						rx_cmd[7:0] = b;
					else if (rx_pos == PosLenHi)
						rx_len[15:8] = b;
					else if (rx_pos == PosLenLo) begin
						rx_len[7:0] = b;
						if (int'(rx_len) >= int'(PayloadLimitDefault))
							rx_skip = 1'b1;
					end
				end else if (int'(rx_pos) == crc_at) begin
					rx_crc_hi = b;
				end else begin
					if ({rx_crc_hi, b} == rx_crc && rx_cmd == CmdSearch)
						queue_search_reply();
					rx_skip = 1'b1;
				end
				if (!rx_skip && rx_pos != '1)
					rx_pos = rx_pos + 1'b1;
			end
		end
		if (last)
			clear_frame();
	endtask

	// one beat on the receive side; returns at the accepting edge
	task automatic send_beat(input logic [7:0] b, input logic last);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_rx_byte(b, last);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_beat(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// stop sending, wait for every reply beat, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reply_beats.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CfgDevType: dev_type_q = val[7:0];
			CfgMac: mac_q = val[47:0];
			CfgIp: ip_q = val[31:0];
			default: ;
		endcase
	endtask

	task automatic fill_noise(input int n);
		frame_buf.delete();
		for (int i = 0; i < n; i++)
			frame_buf.push_back(8'($urandom));
	endtask

	task automatic build_request(input logic [15:0] cmd, input int len);
		logic [15:0] c;
		fill_noise(int'(HdrLen) + len);
		frame_buf[PosLead0] = LeadByte0;
		frame_buf[PosLead1] = LeadByte1;
		frame_buf[PosCmdHi] = cmd[15:8];
		frame_buf[PosCmdLo] = cmd[7:0];
		frame_buf[PosLenHi] = 8'(len >> 8);
		frame_buf[PosLenLo] = 8'(len);
		c = '0;
		for (int i = 0; i < frame_buf.size(); i++)
			c = crc_next(c, frame_buf[i]);
		frame_buf.push_back(c[15:8]);
		frame_buf.push_back(c[7:0]);
	endtask

	task automatic add_trailer(input int n);
		for (int i = 0; i < n; i++)
			frame_buf.push_back(8'($urandom));
	endtask

	task automatic cut_frame(input int n);
		while (frame_buf.size() > n)
			void'(frame_buf.pop_back());
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return $urandom_range(0, 6);
		return $urandom_range(7, 64);
	endfunction

	function automatic frame_kind_t pick_frame_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return FrmSearch;
		if (r < 63) return FrmOtherCmd;
		if (r < 71) return FrmBadCrc;
		if (r < 79) return FrmCutShort;
		if (r < 85) return FrmBadLead0;
		if (r < 90) return FrmBadLead1;
		if (r < 95) return FrmTooLong;
		return FrmNoise;
	endfunction

	task automatic make_random_frame(input frame_kind_t kind);
		logic [15:0] cmd;
		logic [7:0]  b;
		int          idx;
		int          len;
		case (kind)
			FrmSearch: begin
				build_request(CmdSearch, pick_len());
				add_trailer($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
			end
			FrmOtherCmd: begin
				cmd = 16'($urandom);
				if (cmd == CmdSearch)
					cmd = ~cmd;
				build_request(cmd, pick_len());
				add_trailer($urandom_range(0, 2));
			end
			FrmBadCrc: begin
				build_request(CmdSearch, pick_len());
				idx = $urandom_range(2, frame_buf.size() - 1);
				frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
			end
			FrmCutShort: begin
				build_request(CmdSearch, pick_len());
				cut_frame($urandom_range(1, frame_buf.size() - 1));
			end
			FrmBadLead0: begin
				fill_noise($urandom_range(1, 40));
				b = 8'($urandom);
				if (b == LeadByte0)
					b = ~b;
				frame_buf[0] = b;
			end
			FrmBadLead1: begin
				fill_noise($urandom_range(2, 40));
				b = 8'($urandom);
				if (b == LeadByte1)
					b = ~b;
				frame_buf[0] = LeadByte0;
				frame_buf[1] = b;
			end
			FrmTooLong: begin
				build_request(CmdSearch, 0);
				len = $urandom_range(PayloadLimitDefault, 16'hffff);
				frame_buf[PosLenHi] = 8'(len >> 8);
				frame_buf[PosLenLo] = 8'(len);
				add_trailer($urandom_range(0, 6));
			end
			default: fill_noise($urandom_range(1, 12));
		endcase
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			m_tready <= 1'b0;
			stall_left = gap_len() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		reply_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reply_beats.size() == 0) begin
				log_mismatch($sformatf("unexpected reply beat %02h last %0b", m_tdata, m_tlast));
			end else begin
				want = pending_reply_beats.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.last)
					log_mismatch($sformatf("reply beat: expected %02h last %0b, got %02h last %0b",
						want.data, want.last, m_tdata, m_tlast));
			end
		end
	end

	task automatic test_reset_defaults();
		idle_on = 1'b0;
		build_request(CmdSearch, 0);
		send_frame();
		settle();
	endtask

	task automatic test_config_extremes();
		idle_on = 1'b1;
		write_reg(CfgDevType, '1);
		write_reg(CfgMac, '1);
		write_reg(CfgIp, '1);
		build_request(CmdSearch, 1);
		send_frame();
		settle();
		// the spare index must leave every register alone
		write_reg(CfgNone, '0);
		build_request(CmdSearch, 2);
		send_frame();
		settle();
		write_reg(CfgDevType, '0);
		write_reg(CfgMac, '0);
		write_reg(CfgIp, '0);
		build_request(CmdSearch, 0);
		send_frame();
		settle();
		write_reg(CfgDevType, {16'($urandom), 32'($urandom)});
		write_reg(CfgMac, {16'($urandom), 32'($urandom)});
		write_reg(CfgIp, {16'($urandom), 32'($urandom)});
		write_reg(CfgNone, {16'($urandom), 32'($urandom)});
		build_request(CmdSearch, 3);
		send_frame();
		settle();
	endtask

	task automatic test_bad_lead();
		idle_on = 1'b1;
		fill_noise(1);
		frame_buf[0] = 8'h00;
		send_frame();
		frame_buf = '{8'hff, 8'hff, 8'hff};
		send_frame();
		// lone lead byte ends the frame right away
		frame_buf = '{LeadByte0};
		send_frame();
		frame_buf = '{LeadByte0, 8'h00, LeadByte0, LeadByte1};
		send_frame();
		frame_buf = '{LeadByte0, 8'hff};
		send_frame();
		build_request(CmdSearch, 0);
		send_frame();
		settle();
	endtask

	task automatic test_crc_and_command();
		idle_on = 1'b1;
		build_request(CmdSearch, 1);
		frame_buf[frame_buf.size() - 2] = frame_buf[frame_buf.size() - 2] ^ 8'h80;
		send_frame();
		build_request(CmdSearch, 0);
		frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ 8'h01;
		send_frame();
		build_request(16'hff00, 0);
		send_frame();
		build_request({CmdSearch[7:0], CmdSearch[15:8]}, 2);
		send_frame();
		// trailing bytes after the crc are ignored
		build_request(CmdSearch, 0);
		add_trailer(5);
		send_frame();
		// frames that stop short of the crc low byte
		build_request(CmdSearch, 0);
		cut_frame(frame_buf.size() - 1);
		send_frame();
		build_request(CmdSearch, 0);
		cut_frame(int'(PosLenLo) + 1);
		send_frame();
		build_request(CmdSearch, 4);
		cut_frame(10);
		send_frame();
		build_request(CmdSearch, 0);
		send_frame();
		settle();
	endtask

	task automatic test_length_limits();
		idle_on = 1'b0;
		build_request(CmdSearch, 0);
		frame_buf[PosLenHi] = 8'(PayloadLimitDefault >> 8);
		frame_buf[PosLenLo] = 8'(PayloadLimitDefault);
		add_trailer(4);
		send_frame();
		build_request(CmdSearch, 0);
		frame_buf[PosLenHi] = 8'hff;
		frame_buf[PosLenLo] = 8'hff;
		send_frame();
		idle_on = 1'b1;
		build_request(CmdSearch, 1);
		send_frame();
		settle();
	endtask

	// replies queue up behind each other so the receive side has to stall
	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (3) begin
			build_request(CmdSearch, 0);
			send_frame();
		end
		idle_on = 1'b1;
		repeat (3) begin
			build_request(CmdSearch, $urandom_range(0, 3));
			send_frame();
		end
		settle();
	endtask

	task automatic test_random_traffic();
		int items;
		int frames;
		frame_kind_t kind;
		items = 0;
		frames = 0;
		idle_on = 1'b1;
		while (items < RandomItems) begin
			if (frames % 8 == 7) begin
				settle();
				write_reg(CfgIdxW'($urandom_range(0, 3)), {16'($urandom), 32'($urandom)});
				idle_on = ($urandom_range(0, 3) != 0);
			end
			kind = pick_frame_kind();
			make_random_frame(kind);
			items += frame_buf.size();
			send_frame();
			frames++;
		end
		settle();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		dev_type_q = '0;
		mac_q = '0;
		ip_q = '0;
		clear_frame();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_config_extremes();
		test_bad_lead();
		test_crc_and_command();
		test_length_limits();
		test_back_to_back();
		test_random_traffic();

		repeat (TailCycles) @(posedge clk);
		if (mismatch_count == 0 && pending_reply_beats.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
